FILE: sv/tsba_pkg.sv
package tsba_pkg;

  // Default geometry of the slot table.
  localparam int unsigned SLOT_COUNT_DEF    = 512;
  localparam int unsigned MAP_WORD_BITS_DEF = 64;

  // Width of the slot index fields on the ports.
  localparam int unsigned IDX_W = 9;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Result status codes.
  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // The free-slot search works on words of up to this many bits.
  localparam int unsigned FIND_W     = 64;
  localparam int unsigned FIND_IDX_W = $clog2(FIND_W);

  // Fixed-point shift for the reciprocal that splits a slot index into word and bit.
  // The slot index is below 2**DIV_SHIFT.
  localparam int unsigned DIV_SHIFT = 10;

  // Position of the lowest set bit. The lowest set bit is isolated with one
  // add, then the one-hot vector is encoded by OR-ing independent bit positions.
  function automatic logic [FIND_IDX_W-1:0] lowest_set_idx(input logic [FIND_W-1:0] v);
    logic [FIND_W-1:0]     oh;
    logic [FIND_IDX_W-1:0] r;
    oh = v & (~v + FIND_W'(1));
    r  = '0;
    for (int i = 0; i < FIND_W; i++) begin
      if (oh[i]) begin
        r = r | FIND_IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: sv/tsba_map_mem.sv
module tsba_map_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned AW    = 3
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/tsba_find_free.sv
module tsba_find_free #(
  parameter int unsigned WORD_BITS = 64,
  parameter int unsigned LAST_BITS = 64,
  parameter int unsigned SBW       = 6
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [SBW-1:0]       start_bit,
  input  logic                 is_last,
  output logic                 found,
  output logic [SBW-1:0]       bit_idx
);

  // Bits of the last word that lie beyond the end of the table count as used.
  localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);

  logic [WORD_BITS-1:0]            free_bits;
  logic [tsba_pkg::FIND_IDX_W-1:0] pos;

  always_comb begin
    free_bits = ~word & ({WORD_BITS{1'b1}} << start_bit);
    if (is_last) begin
      free_bits = free_bits & LAST_MASK;
    end
    pos     = tsba_pkg::lowest_set_idx(tsba_pkg::FIND_W'(free_bits));
    found   = |free_bits;
    bit_idx = pos[SBW-1:0];
  end

endmodule

FILE: sv/table_slot_bitmap_allocator_top.sv
// Next-fit slot allocator over a used-bit map held in a single-port-write,
// registered-read memory of MAP_WORDS words of MAP_WORD_BITS bits. An allocate
// beat scans upward from the search hint one map word per cycle, grants the
// first free slot, sets its bit and moves the hint just past it; when no slot
// at or above the hint is free it returns status 1 and index 0 and changes
// nothing, and once the hint has reached the end of the table every allocate
// reports full until reset. A free beat clears the named slot's bit and echoes
// the index; indices beyond the table change nothing. One request is in work
// at a time. An allocate reads k map words, k from 1 to MAP_WORDS, one word per
// cycle through the single memory read port; an allocate with the hint already
// at the end reads none. A free splits the index into word and bit with a
// reciprocal multiply, then reads, modifies and writes back the map word. After
// reset a clearing pass writes zero to every map word, during which no beat is
// accepted.
module table_slot_bitmap_allocator_top #(
  parameter int unsigned SLOT_COUNT    = tsba_pkg::SLOT_COUNT_DEF,
  parameter int unsigned MAP_WORD_BITS = tsba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_kind,
  input  logic [tsba_pkg::IDX_W-1:0] in_slot_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_status,
  output logic [tsba_pkg::IDX_W-1:0] out_granted_index
);

  localparam int unsigned IDX_W     = tsba_pkg::IDX_W;
  localparam int unsigned MWB       = MAP_WORD_BITS;
  localparam int unsigned MAP_WORDS = (SLOT_COUNT + MWB - 1) / MWB;
  localparam int unsigned WAW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned SBW       = $clog2(MWB);
  localparam int unsigned SW        = $clog2(SLOT_COUNT + 1);
  localparam int unsigned LAST_BITS = SLOT_COUNT - (MAP_WORDS - 1) * MWB;
  localparam int unsigned DSH       = tsba_pkg::DIV_SHIFT;
  localparam int unsigned RECIP     = (1 << DSH) / MWB;
  localparam int unsigned PW        = 2 * DSH;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FDIV  = 3'd2;
  localparam logic [2:0] S_FRD   = 3'd3;
  localparam logic [2:0] S_EVAL  = 3'd4;
  localparam logic [2:0] S_HOLD  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic             kind_r, kind_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             in_range_r, in_range_nxt;
  logic [DSH-1:0]   q_r, q_nxt;
  logic [WAW-1:0]   cur_word_r, cur_word_nxt;
  logic [SW-1:0]    cur_base_r, cur_base_nxt;
  logic [SBW-1:0]   start_bit_r, start_bit_nxt;
  logic [WAW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [WAW-1:0]   hint_word_r, hint_word_nxt;
  logic [SBW-1:0]   hint_bit_r, hint_bit_nxt;
  logic [SW-1:0]    hint_base_r, hint_base_nxt;
  logic             hint_end_r, hint_end_nxt;
  logic             res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_index_r, res_index_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;

  logic             mem_wr_en;
  logic [WAW-1:0]   mem_wr_addr;
  logic [MWB-1:0]   mem_wr_data;
  logic             mem_rd_en;
  logic [WAW-1:0]   mem_rd_addr;
  logic [MWB-1:0]   mem_rd_data;

  logic             find_found;
  logic [SBW-1:0]   find_bit;
  logic             cur_is_last;
  logic             in_accept;
  logic [SW-1:0]    slot_hit;
  logic [SW-1:0]    slot_next;
  logic [PW-1:0]    prod;
  logic [DSH-1:0]   rem_raw;
  logic [DSH-1:0]   q_fix;
  logic [DSH-1:0]   rem_fix;

  assign in_stall    = (state_r != S_IDLE);
  assign in_accept   = in_valid && !in_stall;
  assign cur_is_last = (cur_word_r == WAW'(MAP_WORDS - 1));
  assign slot_hit    = cur_base_r + SW'(find_bit);
  assign slot_next   = slot_hit + SW'(1);

  // Index split: the floor reciprocal gives a quotient that is exact or one
  // short, and the registered quotient is fixed up in the following cycle.
  assign prod    = PW'(idx_r) * PW'(RECIP);
  assign rem_raw = DSH'(idx_r) - DSH'(q_r * DSH'(MWB));

  always_comb begin
    if (rem_raw >= DSH'(MWB)) begin
      q_fix   = q_r + DSH'(1);
      rem_fix = rem_raw - DSH'(MWB);
    end else begin
      q_fix   = q_r;
      rem_fix = rem_raw;
    end
  end

  tsba_map_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (MWB),
    .AW    (WAW)
  ) u_map_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  tsba_find_free #(
    .WORD_BITS (MWB),
    .LAST_BITS (LAST_BITS),
    .SBW       (SBW)
  ) u_find_free (
    .word      (mem_rd_data),
    .start_bit (start_bit_r),
    .is_last   (cur_is_last),
    .found     (find_found),
    .bit_idx   (find_bit)
  );

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    idx_nxt        = idx_r;
    in_range_nxt   = in_range_r;
    q_nxt          = q_r;
    cur_word_nxt   = cur_word_r;
    cur_base_nxt   = cur_base_r;
    start_bit_nxt  = start_bit_r;
    clr_addr_nxt   = clr_addr_r;
    hint_word_nxt  = hint_word_r;
    hint_bit_nxt   = hint_bit_r;
    hint_base_nxt  = hint_base_r;
    hint_end_nxt   = hint_end_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    mem_wr_en      = 1'b0;
    mem_wr_addr    = cur_word_r;
    mem_wr_data    = mem_rd_data;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = cur_word_r;

    unique case (state_r)
      S_CLEAR: begin
        // Zero one map word per cycle after reset.
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        mem_wr_data  = '0;
        clr_addr_nxt = clr_addr_r + WAW'(1);
        if (clr_addr_r == WAW'(MAP_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          kind_nxt     = in_kind;
          idx_nxt      = in_slot_index;
          in_range_nxt = (32'(in_slot_index) < 32'(SLOT_COUNT));
          if (in_kind == tsba_pkg::KIND_FREE) begin
            state_nxt = S_FDIV;
          end else if (hint_end_r) begin
            // Hint has run off the end of the table: full at once.
            res_status_nxt = tsba_pkg::STATUS_FULL;
            res_index_nxt  = '0;
            state_nxt      = S_HOLD;
          end else begin
            mem_rd_en     = 1'b1;
            mem_rd_addr   = hint_word_r;
            cur_word_nxt  = hint_word_r;
            cur_base_nxt  = hint_base_r;
            start_bit_nxt = hint_bit_r;
            state_nxt     = S_EVAL;
          end
        end
      end
      S_FDIV: begin
        q_nxt     = prod[PW-1:DSH];
        state_nxt = S_FRD;
      end
      S_FRD: begin
        mem_rd_en     = in_range_r;
        mem_rd_addr   = WAW'(q_fix);
        cur_word_nxt  = WAW'(q_fix);
        start_bit_nxt = SBW'(rem_fix);
        state_nxt     = S_EVAL;
      end
      S_EVAL: begin
        if (kind_r == tsba_pkg::KIND_FREE) begin
          mem_wr_en      = in_range_r;
          mem_wr_data    = mem_rd_data & ~(MWB'(1) << start_bit_r);
          res_status_nxt = tsba_pkg::STATUS_DONE;
          res_index_nxt  = idx_r;
          state_nxt      = S_HOLD;
        end else if (find_found) begin
          mem_wr_en      = 1'b1;
          mem_wr_data    = mem_rd_data | (MWB'(1) << find_bit);
          res_status_nxt = tsba_pkg::STATUS_DONE;
          res_index_nxt  = IDX_W'(slot_hit);
          hint_end_nxt   = (slot_next == SW'(SLOT_COUNT));
          if (find_bit == SBW'(MWB - 1)) begin
            hint_word_nxt = cur_word_r + WAW'(1);
            hint_bit_nxt  = '0;
            hint_base_nxt = cur_base_r + SW'(MWB);
          end else begin
            hint_word_nxt = cur_word_r;
            hint_bit_nxt  = find_bit + SBW'(1);
            hint_base_nxt = cur_base_r;
          end
          state_nxt = S_HOLD;
        end else if (cur_is_last) begin
          res_status_nxt = tsba_pkg::STATUS_FULL;
          res_index_nxt  = '0;
          state_nxt      = S_HOLD;
        end else begin
          // Nothing free in this word: fetch the next one, searching from bit 0.
          mem_rd_en     = 1'b1;
          mem_rd_addr   = cur_word_r + WAW'(1);
          cur_word_nxt  = cur_word_r + WAW'(1);
          cur_base_nxt  = cur_base_r + SW'(MWB);
          start_bit_nxt = '0;
        end
      end
      S_HOLD: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_index_nxt  = res_index_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      hint_word_r <= '0;
      hint_bit_r  <= '0;
      hint_base_r <= '0;
      hint_end_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hint_word_r <= hint_word_nxt;
      hint_bit_r  <= hint_bit_nxt;
      hint_base_r <= hint_base_nxt;
      hint_end_r  <= hint_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    idx_r        <= idx_nxt;
    in_range_r   <= in_range_nxt;
    q_r          <= q_nxt;
    cur_word_r   <= cur_word_nxt;
    cur_base_r   <= cur_base_nxt;
    start_bit_r  <= start_bit_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_index = out_index_r;

  // The map memory is never read and written in the same cycle, so no
  // read-during-write forwarding is needed.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("map memory read and written in the same cycle");

  // Only one request is in work: an accepted beat closes the input at once.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("second beat accepted while a request is in work");

  // The hint can reach the end of the table only through a grant.
  a_hint_end_by_grant: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hint_end_r) |-> $past(state_r == S_EVAL && kind_r == tsba_pkg::KIND_ALLOC))
    else $error("search hint reached the end without a grant");

  // A full result always carries index zero.
  a_full_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && res_status_r == tsba_pkg::STATUS_FULL) |-> (res_index_r == '0))
    else $error("full result with a non-zero index");

endmodule
